FILE: hw/rtl/psi_section_duplicate_filter_unit_assert.svh
// Assertion macros for the section filter.
`ifndef PSI_SECTION_DUPLICATE_FILTER_UNIT_ASSERT_SVH
`define PSI_SECTION_DUPLICATE_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, reset masked.
`define PSDF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masked.
`define PSDF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/psdf_pkg.sv
`default_nettype none
package psdf_pkg;
  localparam int TableEntries = 256;
  localparam int IdxW = $clog2(TableEntries);
  localparam int KeyW = 64;
  localparam int VerW = 5;
  localparam int EntryW = KeyW + VerW;

  localparam logic [1:0] CmdSection = 2'd0;
  localparam logic [1:0] CmdClear = 2'd1;
  localparam logic [1:0] CmdEitReset = 2'd2;
  localparam logic [1:0] CmdFilterChg = 2'd3;

  localparam logic [3:0] StPass = 4'd0;
  localparam logic [3:0] StIdle = 4'd1;
  localparam logic [3:0] StMismatch = 4'd2;
  localparam logic [3:0] StShort = 4'd3;
  localparam logic [3:0] StDup = 4'd4;
  localparam logic [3:0] StDupLoop = 4'd5;
  localparam logic [3:0] StDupComplete = 4'd6;
  localparam logic [3:0] StNewComplete = 4'd7;
  localparam logic [3:0] StFull = 4'd8;

  localparam logic [2:0] CfgStreamPid = 3'd0;
  localparam logic [2:0] CfgMatchValue = 3'd1;
  localparam logic [2:0] CfgMatchMask = 3'd2;
  localparam logic [2:0] CfgCacheEnable = 3'd3;
  localparam logic [2:0] CfgServiceId = 3'd4;

  localparam logic [12:0] EitPid = 13'h12;
  localparam logic [7:0] TidEitPf = 8'h4e;
  localparam logic [7:0] TidEitSched = 8'h50;
  localparam logic [7:0] TidEitLast = 8'h6f;
  localparam logic [11:0] MinLen = 12'd5;
  localparam logic [11:0] MinEitLen = 12'd14;
  localparam logic [7:0] VersionUnknown = 8'hff;

  typedef enum logic {SCAN_FIND, SCAN_SUCC} scan_mode_e;

  typedef struct packed {
    logic start;
    scan_mode_e mode;
    logic [KeyW-1:0] key;
  } scan_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic found;
    logic [IdxW-1:0] idx;
    logic [VerW-1:0] ver;
    logic free_found;
    logic [IdxW-1:0] free_idx;
    logic succ_found;
    logic [KeyW-1:0] succ_key;
  } scan_res_t;

  function automatic logic [KeyW-1:0] make_key(logic [7:0] tid, logic [15:0] ext,
                                               logic [7:0] sec, logic [15:0] onid,
                                               logic [15:0] tsid);
    return {tid, ext, sec, onid, tsid};
  endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/psdf_ram.sv
`default_nettype none
module psdf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/psdf_scan.sv
`default_nettype none
module psdf_scan import psdf_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire scan_req_t               req_i,
  input  wire logic [TableEntries-1:0] valid_i,
  input  wire logic [EntryW-1:0]       rdata_i,
  output logic      [IdxW-1:0]         raddr_o,
  output scan_res_t                    res_o
);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);

  logic iss_q, chk_q, done_q;
  logic [IdxW-1:0] cnt_q, chk_idx_q;
  scan_mode_e mode_q;
  logic [KeyW-1:0] key_q, best_q;
  logic found_q, free_q, succ_q;
  logic [IdxW-1:0] idx_q, free_idx_q;
  logic [VerW-1:0] ver_q;
  logic [KeyW-1:0] e_key;
  logic [VerW-1:0] e_ver;
  logic e_v;

  assign raddr_o = cnt_q;
  assign e_key = rdata_i[EntryW-1:VerW];
  assign e_ver = rdata_i[VerW-1:0];
  assign e_v = valid_i[chk_idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q <= 1'b0;
      chk_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
      chk_idx_q <= '0;
      mode_q <= SCAN_FIND;
      key_q <= '0;
      best_q <= '0;
      found_q <= 1'b0;
      free_q <= 1'b0;
      succ_q <= 1'b0;
      idx_q <= '0;
      free_idx_q <= '0;
      ver_q <= '0;
    end else begin
      chk_q <= iss_q;
      chk_idx_q <= cnt_q;
      done_q <= chk_q && (chk_idx_q == LastIdx);
      if (req_i.start) begin
        iss_q <= 1'b1;
        cnt_q <= '0;
        mode_q <= req_i.mode;
        key_q <= req_i.key;
        found_q <= 1'b0;
        free_q <= 1'b0;
        succ_q <= 1'b0;
      end else if (iss_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          iss_q <= 1'b0;
        end
      end
      if (chk_q) begin
        unique case (mode_q)
          SCAN_FIND: begin
            if (e_v && (e_key == key_q) && !found_q) begin
              found_q <= 1'b1;
              idx_q <= chk_idx_q;
              ver_q <= e_ver;
            end
            if (!e_v && !free_q) begin
              free_q <= 1'b1;
              free_idx_q <= chk_idx_q;
            end
          end
          SCAN_SUCC: begin
            if (e_v && (e_key > key_q) && (!succ_q || (e_key < best_q))) begin
              succ_q <= 1'b1;
              best_q <= e_key;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    res_o.busy = iss_q || chk_q || req_i.start;
    res_o.done = done_q;
    res_o.found = found_q;
    res_o.idx = idx_q;
    res_o.ver = ver_q;
    res_o.free_found = free_q;
    res_o.free_idx = free_idx_q;
    res_o.succ_found = succ_q;
    res_o.succ_key = best_q;
  end
endmodule
`default_nettype wire

FILE: hw/rtl/psi_section_duplicate_filter_unit.sv
// Section header filter with a cache of seen section versions.
// Input stream: one word per parsed section header or command; tuser holds
// the command, tdata the header fields. Output stream: one word per input
// word with status, deliver flag and tracked EIT version.
// Configuration: write cfg_we_i with cfg_idx_i and cfg_data_i while idle.
// Flow: commands and sections that need no lookup go straight to S_FIN,
// which loads the result word into the output register once that register
// is free; the unit then returns to idle and takes the next word.
// A cached section takes one scan of the key/version RAM, which walks its
// entries in turn through the single read port of that RAM. A completeness
// walk adds the setup state S_CST, one scan for section 0 and one scan per
// successor, so a full EIT table of 256 sections costs up to 257 scans.
// One item is worked on at a time; tready is high only while idle. A
// finished result sits in the output register, so the next word is taken
// while the receiver stalls; that item waits to finish until the register
// frees up.
// Reset clears all entry valid bits at once, forgets the first duplicate,
// sets the tracked EIT version to unknown and loads the register defaults.
`default_nettype none
`include "psi_section_duplicate_filter_unit_assert.svh"
module psi_section_duplicate_filter_unit import psdf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // table id, syntax flag, section length, extension, version, current flag,
  // section number, last section number, stream id, network id, zero pad
  input  wire logic [95:0] s_axis_tdata,
  // cmd
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status, deliver, eit_version_now, eit_version_changed, zero pad
  output logic      [15:0] m_axis_tdata
);
  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_CST, S_W0, S_WS, S_FIN} state_e;

  state_e state_q;
  logic [12:0] pid_q;
  logic [7:0] mval_q, mmask_q;
  logic cache_q;
  logic [15:0] svc_q;
  logic [TableEntries-1:0] valid_q;
  logic fdv_q;
  logic [KeyW-1:0] fdk_q;
  logic [7:0] track_q;

  logic [7:0] it_tid_q, it_last_q, cur_q;
  logic [15:0] it_ext_q, it_onid_q, it_tsid_q;
  logic [VerW-1:0] it_ver_q;
  logic [KeyW-1:0] it_key_q;
  logic dup_q;
  logic [3:0] st_q;
  logic dlv_q, chg_q;

  logic out_vld_q;
  logic [15:0] out_data_q;

  scan_req_t req_q;
  scan_res_t res;
  logic [IdxW-1:0] raddr;
  logic [EntryW-1:0] rdata;
  logic ram_we_q;
  logic [IdxW-1:0] ram_waddr_q;
  logic [EntryW-1:0] ram_wdata_q;

  logic [1:0] in_cmd;
  logic [7:0] in_tid, in_sec, in_last;
  logic in_syn, in_cur;
  logic [11:0] in_len;
  logic [15:0] in_ext, in_tsid, in_onid, k_tsid, k_onid;
  logic [VerW-1:0] in_ver;
  logic acc, is_eit_pid, c_dummy, c_mis, c_short, eit_upd, out_free;
  logic [7:0] s_sec;
  logic s_fields_ok, s_step_ok;

  assign in_cmd = s_axis_tuser;
  assign in_tid = s_axis_tdata[7:0];
  assign in_syn = s_axis_tdata[8];
  assign in_len = s_axis_tdata[20:9];
  assign in_ext = s_axis_tdata[36:21];
  assign in_ver = s_axis_tdata[41:37];
  assign in_cur = s_axis_tdata[42];
  assign in_sec = s_axis_tdata[50:43];
  assign in_last = s_axis_tdata[58:51];
  assign in_tsid = s_axis_tdata[74:59];
  assign in_onid = s_axis_tdata[90:75];

  assign s_axis_tready = (state_q == S_IDLE);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = out_data_q;

  always_comb begin
    is_eit_pid = (pid_q == EitPid);
    c_dummy = is_eit_pid && (mval_q == 8'd0) && (mmask_q == 8'd0);
    c_mis = ((in_tid ^ mval_q) & mmask_q) != 8'd0;
    c_short = (in_len < MinLen) ||
              ((in_tid >= TidEitPf) && (in_tid <= TidEitLast) && (in_len < MinEitLen));
    k_tsid = is_eit_pid ? in_tsid : 16'd0;
    k_onid = is_eit_pid ? in_onid : 16'd0;
    eit_upd = (in_tid == TidEitPf) && (in_ext == svc_q) && ({3'b000, in_ver} != track_q);
    s_sec = res.succ_key[39:32];
    s_fields_ok = (res.succ_key[63:56] == it_tid_q) && (res.succ_key[55:40] == it_ext_q) &&
                  (res.succ_key[31:16] == it_onid_q) && (res.succ_key[15:0] == it_tsid_q);
    s_step_ok = ({1'b0, s_sec} == ({1'b0, cur_q} + 9'd1)) ||
                ({1'b0, s_sec} == ({1'b0, cur_q} + 9'd8));
  end

  psdf_ram #(.Width(EntryW), .Depth(TableEntries)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we_q),
    .waddr_i(ram_waddr_q),
    .wdata_i(ram_wdata_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  psdf_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_q),
    .valid_i(valid_q),
    .rdata_i(rdata),
    .raddr_o(raddr),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pid_q <= 13'd18;
      mval_q <= 8'd0;
      mmask_q <= 8'd0;
      cache_q <= 1'b1;
      svc_q <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStreamPid: pid_q <= cfg_data_i[12:0];
        CfgMatchValue: mval_q <= cfg_data_i[7:0];
        CfgMatchMask: mmask_q <= cfg_data_i[7:0];
        CfgCacheEnable: cache_q <= cfg_data_i[0];
        CfgServiceId: svc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      fdv_q <= 1'b0;
      fdk_q <= '0;
      track_q <= VersionUnknown;
      out_vld_q <= 1'b0;
      out_data_q <= '0;
      req_q <= '0;
      ram_we_q <= 1'b0;
      ram_waddr_q <= '0;
      ram_wdata_q <= '0;
      it_tid_q <= '0;
      it_last_q <= '0;
      cur_q <= '0;
      it_ext_q <= '0;
      it_onid_q <= '0;
      it_tsid_q <= '0;
      it_ver_q <= '0;
      it_key_q <= '0;
      dup_q <= 1'b0;
      st_q <= StPass;
      dlv_q <= 1'b0;
      chg_q <= 1'b0;
    end else begin
      req_q.start <= 1'b0;
      ram_we_q <= 1'b0;
      if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            st_q <= StPass;
            dlv_q <= 1'b0;
            chg_q <= 1'b0;
            dup_q <= 1'b0;
            it_tid_q <= in_tid;
            it_ext_q <= in_ext;
            it_ver_q <= in_ver;
            it_last_q <= in_last;
            it_onid_q <= k_onid;
            it_tsid_q <= k_tsid;
            it_key_q <= make_key(in_tid, in_ext, in_sec, k_onid, k_tsid);
            state_q <= S_FIN;
            priority if (in_cmd == CmdClear) begin
              valid_q <= '0;
            end else if (in_cmd == CmdEitReset) begin
              track_q <= VersionUnknown;
            end else if (in_cmd == CmdFilterChg) begin
              fdv_q <= 1'b0;
              fdk_q <= '0;
            end else if (c_dummy) begin
              st_q <= StIdle;
            end else if (c_mis) begin
              st_q <= StMismatch;
            end else if (c_short) begin
              st_q <= StShort;
            end else begin
              dlv_q <= 1'b1;
              if (in_syn && in_cur) begin
                if (eit_upd) begin
                  track_q <= {3'b000, in_ver};
                  chg_q <= 1'b1;
                end
                if (cache_q) begin
                  req_q.start <= 1'b1;
                  req_q.mode <= SCAN_FIND;
                  req_q.key <= make_key(in_tid, in_ext, in_sec, k_onid, k_tsid);
                  state_q <= S_LOOK;
                end
              end
            end
          end
        end
        S_LOOK: begin
          if (res.done) begin
            if (res.found && (res.ver == it_ver_q)) begin
              dlv_q <= 1'b0;
              dup_q <= 1'b1;
              if (!fdv_q) begin
                fdv_q <= 1'b1;
                fdk_q <= it_key_q;
                st_q <= StDup;
              end else begin
                st_q <= (fdk_q == it_key_q) ? StDupLoop : StDup;
              end
              state_q <= S_CST;
            end else begin
              fdv_q <= 1'b0;
              fdk_q <= '0;
              if (res.found) begin
                ram_we_q <= 1'b1;
                ram_waddr_q <= res.idx;
                ram_wdata_q <= {it_key_q, it_ver_q};
                state_q <= S_FIN;
              end else if (res.free_found) begin
                ram_we_q <= 1'b1;
                ram_waddr_q <= res.free_idx;
                ram_wdata_q <= {it_key_q, it_ver_q};
                valid_q[res.free_idx] <= 1'b1;
                state_q <= S_CST;
              end else begin
                st_q <= StFull;
                state_q <= S_FIN;
              end
            end
          end
        end
        S_CST: begin
          if (!(((it_tid_q == TidEitPf) || (it_tid_q == TidEitSched)) &&
                (svc_q == it_ext_q))) begin
            state_q <= S_FIN;
          end else if (it_last_q == 8'd0) begin
            st_q <= dup_q ? StDupComplete : StNewComplete;
            state_q <= S_FIN;
          end else begin
            req_q.start <= 1'b1;
            req_q.mode <= SCAN_FIND;
            req_q.key <= make_key(it_tid_q, it_ext_q, 8'd0, it_onid_q, it_tsid_q);
            state_q <= S_W0;
          end
        end
        S_W0: begin
          if (res.done) begin
            if (res.found) begin
              cur_q <= 8'd0;
              req_q.start <= 1'b1;
              req_q.mode <= SCAN_SUCC;
              req_q.key <= make_key(it_tid_q, it_ext_q, 8'd0, it_onid_q, it_tsid_q);
              state_q <= S_WS;
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        S_WS: begin
          if (res.done) begin
            if (!res.succ_found || !s_fields_ok || !s_step_ok) begin
              state_q <= S_FIN;
            end else if (s_sec == it_last_q) begin
              st_q <= dup_q ? StDupComplete : StNewComplete;
              state_q <= S_FIN;
            end else begin
              cur_q <= s_sec;
              req_q.start <= 1'b1;
              req_q.mode <= SCAN_SUCC;
              req_q.key <= res.succ_key;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_vld_q <= 1'b1;
            out_data_q <= {2'b00, chg_q, track_q, dlv_q, st_q};
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `PSDF_ASSERT_IMP(a_done_when_waiting, res.done, (state_q == S_LOOK) || (state_q == S_W0) || (state_q == S_WS), "scan finished outside a waiting state")
  `PSDF_ASSERT_IMP(a_no_write_in_scan, ram_we_q, !res.busy, "RAM written during a scan")
  `PSDF_ASSERT_IMP(a_dup_not_delivered, m_axis_tvalid && m_axis_tdata[4], (m_axis_tdata[3:0] != StDup) && (m_axis_tdata[3:0] != StDupLoop) && (m_axis_tdata[3:0] != StDupComplete), "duplicate delivered")
  `PSDF_ASSERT_NXT(a_accept_leaves_idle, acc, state_q != S_IDLE, "accepted word did not start work")
endmodule
`default_nettype wire

FILE: test/psi_section_duplicate_filter_unit_test.sv
`default_nettype none
module psi_section_duplicate_filter_unit_test;
  import psdf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  tid;
    logic        syn;
    logic [11:0] len;
    logic [15:0] ext;
    logic [4:0]  ver;
    logic        cur;
    logic [7:0]  sec;
    logic [7:0]  last;
    logic [15:0] tsid;
    logic [15:0] onid;
  } hdr_t;

  typedef struct {
    logic [3:0] status;
    logic       deliver;
    logic [7:0] eit_ver;
    logic       changed;
  } verdict_t;

  typedef struct {
    bit       is_cfg;
    logic [2:0] cfg_idx;
    logic [15:0] cfg_val;
    hdr_t     hdr;
    bit       known;
    verdict_t want;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // table id, syntax flag, section length, extension, version, current flag,
  // section number, last section number, stream id, network id, zero pad
  logic [95:0] s_axis_tdata;
  // cmd
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // status, deliver, eit_version_now, eit_version_changed, zero pad
  logic [15:0] m_axis_tdata;

  psi_section_duplicate_filter_unit dut (.*);

  // predictor state
  logic [63:0] cache_keys [TableEntries];
  logic [4:0]  cache_vers [TableEntries];
  bit          cache_valid [TableEntries];
  logic [63:0] dup_key;
  bit          dup_valid;
  logic [7:0]  trk_ver;
  logic [12:0] r_pid;
  logic [7:0]  r_mval;
  logic [7:0]  r_mmask;
  logic        r_cache;
  logic [15:0] r_svc;

  verdict_t verdicts_q[$];
  int errors;
  int hold_cycles;
  bit calm;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("Mismatches found");
    $finish;
  end

  task automatic report(string msg);
    $display("%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int find_key(logic [63:0] k);
    for (int i = 0; i < TableEntries; i++)
      if (cache_valid[i] && cache_keys[i] == k) return i;
    return -1;
  endfunction

  function automatic int find_free();
    for (int i = 0; i < TableEntries; i++)
      if (!cache_valid[i]) return i;
    return -1;
  endfunction

  function automatic int find_next(logic [63:0] k);
    int best;
    best = -1;
    for (int i = 0; i < TableEntries; i++)
      if (cache_valid[i] && cache_keys[i] > k && (best < 0 || cache_keys[i] < cache_keys[best]))
        best = i;
    return best;
  endfunction

  function automatic bit eit_complete(logic [7:0] tid, logic [15:0] ext, logic [15:0] onid,
                                      logic [15:0] tsid, logic [7:0] last);
    logic [63:0] ck;
    logic [63:0] k;
    int cur;
    int s;
    int idx;
    if (!((tid == TidEitPf || tid == TidEitSched) && r_svc == ext)) return 0;
    if (last == 0) return 1;
    ck = {tid, ext, 8'd0, onid, tsid};
    if (find_key(ck) < 0) return 0;
    cur = 0;
    forever begin
      idx = find_next(ck);
      if (idx < 0) return 0;
      k = cache_keys[idx];
      s = k[39:32];
      if (k[63:56] != tid || k[55:40] != ext || k[31:16] != onid || k[15:0] != tsid)
        return 0;
      if (!(s == cur + 1 || s == cur + 8)) return 0;
      if (s == last) return 1;
      cur = s;
      ck = k;
    end
  endfunction

  function automatic verdict_t classify(hdr_t h);
    verdict_t r;
    logic [15:0] onid;
    logic [15:0] tsid;
    logic [63:0] key;
    int idx;
    int slot;
    r.status = StPass;
    r.deliver = 0;
    r.changed = 0;
    onid = h.onid;
    tsid = h.tsid;
    if (h.cmd == CmdClear) begin
      foreach (cache_valid[i]) cache_valid[i] = 0;
    end else if (h.cmd == CmdEitReset) begin
      trk_ver = VersionUnknown;
    end else if (h.cmd == CmdFilterChg) begin
      dup_valid = 0;
    end else if (r_pid == EitPid && r_mval == 0 && r_mmask == 0) begin
      r.status = StIdle;
    end else if (((h.tid ^ r_mval) & r_mmask) != 0) begin
      r.status = StMismatch;
    end else if (h.len < MinLen || (h.tid >= TidEitPf && h.tid <= TidEitLast && h.len < MinEitLen))
    begin
      r.status = StShort;
    end else begin
      r.deliver = 1;
      if (h.syn && h.cur) begin
        if (r_pid != EitPid) begin
          onid = 0;
          tsid = 0;
        end
        if (h.tid == TidEitPf && h.ext == r_svc && {3'b0, h.ver} != trk_ver) begin
          trk_ver = {3'b0, h.ver};
          r.changed = 1;
        end
        if (r_cache) begin
          key = {h.tid, h.ext, h.sec, onid, tsid};
          idx = find_key(key);
          if (idx >= 0 && cache_vers[idx] == h.ver) begin
            r.deliver = 0;
            r.status = StDup;
            if (!dup_valid) begin
              dup_valid = 1;
              dup_key = key;
            end else if (dup_key == key) begin
              r.status = StDupLoop;
            end
            if (eit_complete(h.tid, h.ext, onid, tsid, h.last)) r.status = StDupComplete;
          end else begin
            if (idx >= 0) begin
              cache_vers[idx] = h.ver;
            end else begin
              slot = find_free();
              if (slot < 0) begin
                r.status = StFull;
              end else begin
                cache_keys[slot] = key;
                cache_vers[slot] = h.ver;
                cache_valid[slot] = 1;
                if (eit_complete(h.tid, h.ext, onid, tsid, h.last)) r.status = StNewComplete;
              end
            end
            dup_valid = 0;
          end
        end
      end
    end
    r.eit_ver = trk_ver;
    return r;
  endfunction

  always @(posedge clk_i) begin
    verdict_t w;
    if (m_axis_tvalid && m_axis_tready) begin
      if (verdicts_q.size() == 0) begin
        report($sformatf("unexpected result word %h", m_axis_tdata));
      end else begin
        w = verdicts_q.pop_front();
        if (m_axis_tdata[3:0] != w.status)
          report($sformatf("status %0d, want %0d", m_axis_tdata[3:0], w.status));
        if (m_axis_tdata[4] != w.deliver)
          report($sformatf("deliver %0d, want %0d", m_axis_tdata[4], w.deliver));
        if (m_axis_tdata[12:5] != w.eit_ver)
          report($sformatf("eit version %0d, want %0d", m_axis_tdata[12:5], w.eit_ver));
        if (m_axis_tdata[13] != w.changed)
          report($sformatf("eit changed %0d, want %0d", m_axis_tdata[13], w.changed));
      end
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 14);
      end
    end
  end

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (verdicts_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgStreamPid: r_pid = val[12:0];
      CfgMatchValue: r_mval = val[7:0];
      CfgMatchMask: r_mmask = val[7:0];
      CfgCacheEnable: r_cache = val[0];
      CfgServiceId: r_svc = val;
      default: ;
    endcase
  endtask

  task automatic send(hdr_t h, bit known, verdict_t want);
    verdict_t p;
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= h.cmd;
    s_axis_tdata <= {5'b0, h.onid, h.tsid, h.last, h.sec, h.cur, h.ver, h.ext, h.len,
                     h.syn, h.tid};
    do @(posedge clk_i); while (!s_axis_tready);
    p = classify(h);
    verdicts_q.insert(verdicts_q.size(), known ? want : p);
    if (!calm && $urandom_range(99) < 14) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic hdr_t sec_hdr(logic [7:0] tid, logic [15:0] ext, logic [4:0] ver,
                                   logic [7:0] sec, logic [7:0] last);
    hdr_t h;
    h = '{cmd: CmdSection, tid: tid, syn: 1, len: 12'd100, ext: ext, ver: ver, cur: 1,
          sec: sec, last: last, tsid: 16'h0001, onid: 16'h0002};
    return h;
  endfunction

  function automatic hdr_t cmd_hdr(logic [1:0] c);
    hdr_t h;
    h = sec_hdr(8'h00, 16'h0, 5'd0, 8'd0, 8'd0);
    h.cmd = c;
    return h;
  endfunction

  function automatic hdr_t rand_hdr();
    hdr_t h;
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      h = '{cmd: 2'($urandom_range(3)), tid: 8'($urandom), syn: 1'($urandom),
            len: 12'($urandom), ext: 16'($urandom), ver: 5'($urandom), cur: 1'($urandom),
            sec: 8'($urandom), last: 8'($urandom), tsid: 16'($urandom),
            onid: 16'($urandom)};
      return h;
    end
    h = sec_hdr($urandom_range(1) ? TidEitPf : ($urandom_range(1) ? TidEitSched : 8'h42),
                $urandom_range(3) != 0 ? r_svc : 16'($urandom_range(2)),
                5'($urandom_range(1)), $urandom_range(1) ? 8'($urandom_range(5)) :
                8'($urandom_range(2) * 8), $urandom_range(1) ? 8'($urandom_range(5)) : 8'd16);
    h.tsid = 16'($urandom_range(1));
    h.onid = 16'($urandom_range(1));
    if (pick < 16) h.cmd = 2'($urandom_range(1, 3));
    if (pick >= 16 && pick < 20) h.len = 12'($urandom_range(13));
    if (pick >= 20 && pick < 24) h.cur = 0;
    if (pick >= 24 && pick < 27) h.syn = 0;
    return h;
  endfunction

  row_t plan[$];
  verdict_t none;

  function automatic row_t cfg_row(logic [2:0] idx, logic [15:0] val);
    row_t r;
    r.is_cfg = 1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    r.known = 0;
    return r;
  endfunction

  function automatic row_t hdr_row(hdr_t h, bit known, verdict_t want);
    row_t r;
    r.is_cfg = 0;
    r.hdr = h;
    r.known = known;
    r.want = want;
    return r;
  endfunction

  function automatic void add_row(row_t r);
    plan.insert(plan.size(), r);
  endfunction

  initial begin
    hdr_t h;
    verdict_t v;
    errors = 0;
    hold_cycles = 0;
    calm = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    foreach (cache_valid[i]) cache_valid[i] = 0;
    dup_valid = 0;
    dup_key = '0;
    trk_ver = VersionUnknown;
    r_pid = 13'd18;
    r_mval = 0;
    r_mmask = 0;
    r_cache = 1;
    r_svc = 0;
    none = '{status: StPass, deliver: 0, eit_ver: VersionUnknown, changed: 0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    v = none;
    v.status = StIdle;
    add_row(hdr_row(sec_hdr(TidEitPf, 0, 3, 0, 0), 1, v));
    add_row(hdr_row(cmd_hdr(CmdClear), 1, none));
    add_row(hdr_row(cmd_hdr(CmdEitReset), 1, none));
    add_row(hdr_row(cmd_hdr(CmdFilterChg), 1, none));
    add_row(cfg_row(CfgMatchValue, 16'h40));
    add_row(cfg_row(CfgMatchMask, 16'h00));
    add_row(cfg_row(CfgServiceId, 16'h1234));
    h = sec_hdr(8'h00, 0, 0, 0, 0);
    h.len = 4;
    v = none;
    v.status = StShort;
    add_row(hdr_row(h, 1, v));
    h = sec_hdr(TidEitLast, 0, 0, 0, 0);
    h.len = 13;
    add_row(hdr_row(h, 1, v));
    add_row(hdr_row(sec_hdr(TidEitPf, 16'h1234, 7, 0, 0), 0, none));
    add_row(hdr_row(sec_hdr(TidEitPf, 16'h1234, 7, 0, 0), 0, none));
    add_row(hdr_row(sec_hdr(TidEitSched, 16'h1234, 2, 0, 9), 0, none));
    add_row(hdr_row(sec_hdr(TidEitSched, 16'h1234, 2, 1, 9), 0, none));
    add_row(hdr_row(sec_hdr(TidEitSched, 16'h1234, 2, 9, 9), 0, none));
    add_row(hdr_row(sec_hdr(TidEitSched, 16'h1234, 2, 9, 9), 0, none));
    add_row(hdr_row(sec_hdr(TidEitSched, 16'h1234, 2, 1, 9), 0, none));
    add_row(hdr_row(sec_hdr(TidEitSched, 16'h1234, 2, 1, 9), 0, none));
    h = '{cmd: CmdSection, tid: 8'hff, syn: 1, len: 12'hfff, ext: 16'hffff, ver: 5'h1f,
          cur: 1, sec: 8'hff, last: 8'hff, tsid: 16'hffff, onid: 16'hffff};
    add_row(hdr_row(h, 0, none));
    h.syn = 0;
    add_row(hdr_row(h, 0, none));
    h.syn = 1;
    h.cur = 0;
    add_row(hdr_row(h, 0, none));
    add_row(cfg_row(CfgMatchMask, 16'hf0));
    v = none;
    v.status = StMismatch;
    v.eit_ver = 8'd7;
    add_row(hdr_row(sec_hdr(8'h00, 0, 0, 0, 0), 1, v));
    add_row(cfg_row(CfgStreamPid, 16'h1fff));
    add_row(cfg_row(CfgCacheEnable, 16'h0));
    add_row(hdr_row(sec_hdr(TidEitPf, 16'h1234, 8, 0, 0), 0, none));
    add_row(cfg_row(CfgCacheEnable, 16'h1));
    add_row(cfg_row(CfgMatchMask, 16'h00));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].cfg_idx, plan[i].cfg_val);
      else send(plan[i].hdr, plan[i].known, plan[i].want);
    end

    // fill the cache past capacity with distinct keys
    for (int i = 0; i < TableEntries + 4; i++) begin
      h = sec_hdr(8'h01, 16'(i), 0, 0, 0);
      send(h, 0, none);
    end
    send(cmd_hdr(CmdClear), 0, none);

    for (int n = 0; n < 420; n++) begin
      if (n % 140 == 0) begin
        write_reg(CfgStreamPid, $urandom_range(1) ? 16'(EitPid) :
                  ($urandom_range(1) ? 16'h0 : 16'h1fff));
        write_reg(CfgMatchValue, $urandom_range(1) ? 16'h40 : 16'($urandom_range(255)));
        write_reg(CfgMatchMask, $urandom_range(3) != 0 ? 16'h0 : 16'h80);
        write_reg(CfgCacheEnable, 16'($urandom_range(5) != 0));
        write_reg(CfgServiceId, $urandom_range(1) ? 16'h0 : 16'hffff);
      end
      calm = (n >= 150 && n < 250);
      if (n == 100) hold_cycles = 3000;
      if (n == 300) drain();
      send(rand_hdr(), 0, none);
    end
    drain();
    repeat (600) @(posedge clk_i);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire
